// ----- hw/rtl/lowest_rtt_path_select_top_assert.svh -----
// ---------------------------------------------------------------------------
// Lowest RTT path select assertion macros
// Shared concurrent assertion forms used by the block's RTL.
// ---------------------------------------------------------------------------
`ifndef LOWEST_RTT_PATH_SELECT_TOP_ASSERT_SVH
`define LOWEST_RTT_PATH_SELECT_TOP_ASSERT_SVH

// Same-cycle implication.
`define LRPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrps assertion failed");

// Next-cycle implication.
`define LRPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrps assertion failed");

`endif

// ----- hw/rtl/lrps_pkg.sv -----
// ---------------------------------------------------------------------------
// Lowest RTT path select package
// Widths, constants and shared types of the path selector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrps_pkg;

   localparam int unsigned ID_W        = 3;
   localparam int unsigned SEQ_W       = 32;
   localparam int unsigned WIN_W       = 16;
   localparam int unsigned SRTT_W      = 32;
   localparam int unsigned RTT_SHIFT   = 3;
   localparam int unsigned RTT_W       = SRTT_W - RTT_SHIFT;
   localparam int unsigned FACTOR_W    = 4;
   localparam int unsigned BOUND_W     = 32;
   localparam int unsigned MAX_PATHS   = 8;

   localparam int unsigned REQ_TDATA_W = 136;
   localparam int unsigned RSP_TDATA_W = 40;

   localparam int unsigned CSR_ADDR_W  = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [FACTOR_W-1:0] BACKLOG_RESET = 4'd2;
   localparam logic [RTT_W-1:0]    RTT_ALL_ONES  = '1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BACKLOG_FACTOR = 2'd0
   } csr_addr_type;

   typedef struct packed {
      logic [ID_W-1:0]   path_id;
      logic              is_active;
      logic              has_buffer;
      logic              may_send;
      logic              is_backup;
      logic [SEQ_W-1:0]  write_seq_num;
      logic [SEQ_W-1:0]  next_seq_num;
      logic [WIN_W-1:0]  cong_window;
      logic [WIN_W-1:0]  seg_size;
      logic [SRTT_W-1:0] smoothed_rtt;
      logic              last_path;
   } path_req_type;

   typedef struct packed {
      logic [ID_W-1:0]    path_id;
      logic               eligible;
      logic               is_backup;
      logic [SEQ_W-1:0]   backlog;
      logic [BOUND_W-1:0] win_bytes;
      logic [RTT_W-1:0]   rtt;
      logic               last_path;
   } path_info_type;

   typedef struct packed {
      logic             found;
      logic [ID_W-1:0]  chosen_id;
      logic [RTT_W-1:0] chosen_rtt;
   } rsp_type;

endpackage

// ----- hw/rtl/lowest_rtt_path_select_top.sv -----
// ---------------------------------------------------------------------------
// Lowest RTT path select top level
// Streams candidate path descriptors and reports the lowest-RTT path of
// each round.
// ---------------------------------------------------------------------------
// Send one transfer per candidate path; the transfer with req_tlast high
// closes the round. A path qualifies when it is active, has buffer space,
// may send and its unsent backlog (write minus next, mod 2^32) does not
// exceed backlog_factor * cong_window * seg_size, wrapped to 32 bits. Among
// qualifying paths the lowest smoothed_rtt >> 3 wins; on equal RTT a primary
// path displaces a backup winner, otherwise the earlier path stays. The
// closing transfer yields exactly one result transfer; other transfers yield
// none. The block takes one path per clock: the descriptor passes an input
// register, a stage holding the cwnd*mss product, and a single compare and
// update stage against the round's best path, which loads the result
// register. The result register is decoupled from the input side, so paths
// keep flowing while a result waits; only a second closing transfer stalls
// behind an untaken result.
// Write backlog_factor (address 0, reset 2) only while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lowest_rtt_path_select_top #(
   parameter int unsigned MAX_PATHS = lrps_pkg::MAX_PATHS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata, low bit up: path_id[2:0], is_active[3], has_buffer[4],
   // may_send[5], is_backup[6], write_seq_num[38:7], next_seq_num[70:39],
   // cong_window[86:71], seg_size[102:87], smoothed_rtt[134:103], zero[135]
   input  logic [lrps_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 req_tlast,
   // Response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata, low bit up: found[0], chosen_id[3:1], chosen_rtt[32:4],
   // zero[39:33]
   output logic [lrps_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // Register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lrps_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lrps_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lrps_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic [lrps_pkg::FACTOR_W-1:0] backlog_factor_ff, backlog_factor_in;
   logic                          csr_write;
   logic                          csr_hit;

   lrps_pkg::path_req_type        req_data;
   lrps_pkg::path_info_type       info_data;
   logic                          info_valid;
   logic                          info_ready;
   lrps_pkg::rsp_type             rsp_data;

   // Register port: always ready, write lands on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr == lrps_pkg::CSR_BACKLOG_FACTOR);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      backlog_factor_in = backlog_factor_ff;
      if (csr_write && csr_hit) begin
         backlog_factor_in = csr_pwdata[lrps_pkg::FACTOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backlog_factor_ff <= lrps_pkg::BACKLOG_RESET;
      end else begin
         backlog_factor_ff <= backlog_factor_in;
      end
   end

   assign csr_prdata = csr_hit ? lrps_pkg::CSR_DATA_W'(backlog_factor_ff) : '0;

   // Unpack the request transfer.
   always_comb begin
      req_data.path_id       = req_tdata[2:0];
      req_data.is_active     = req_tdata[3];
      req_data.has_buffer    = req_tdata[4];
      req_data.may_send      = req_tdata[5];
      req_data.is_backup     = req_tdata[6];
      req_data.write_seq_num = req_tdata[38:7];
      req_data.next_seq_num  = req_tdata[70:39];
      req_data.cong_window   = req_tdata[86:71];
      req_data.seg_size      = req_tdata[102:87];
      req_data.smoothed_rtt  = req_tdata[134:103];
      req_data.last_path     = req_tlast;
   end

   lrps_path_stage #(
      .MAX_PATHS  (MAX_PATHS)
   ) u_path_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_data   (req_data),
      .info_valid (info_valid),
      .info_ready (info_ready),
      .info_data  (info_data)
   );

   lrps_rtt_select u_rtt_select (
      .clock          (clock),
      .reset          (reset),
      .backlog_factor (backlog_factor_ff),
      .info_valid     (info_valid),
      .info_ready     (info_ready),
      .info_data      (info_data),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_data       (rsp_data)
   );

   // Pack the response transfer, zero fill to whole bytes.
   assign rsp_tdata = {7'd0, rsp_data.chosen_rtt, rsp_data.chosen_id, rsp_data.found};

endmodule

// ----- hw/rtl/lrps_path_stage.sv -----
// ---------------------------------------------------------------------------
// Path descriptor stage
// Input register, then a registered stage holding the window product,
// backlog and eligibility of one candidate path.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrps_path_stage #(
   parameter int unsigned MAX_PATHS = lrps_pkg::MAX_PATHS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lrps_pkg::path_req_type req_data,
   output logic                   info_valid,
   input  logic                   info_ready,
   output lrps_pkg::path_info_type info_data
);

   logic                    a_valid_ff, a_valid_in;
   lrps_pkg::path_req_type  a_data_ff;
   logic                    b_valid_ff, b_valid_in;
   lrps_pkg::path_info_type b_data_ff, b_data_in;
   logic                    b_ready;
   logic                    a_load;
   logic                    b_load;

   assign b_ready   = !b_valid_ff || info_ready;
   assign req_ready = !a_valid_ff || b_ready;
   assign a_load    = req_valid && req_ready;
   assign b_load    = a_valid_ff && b_ready;

   always_comb begin
      a_valid_in = req_ready ? req_valid : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   end

   // Derive per-path terms; the factor multiply happens one stage later.
   always_comb begin
      b_data_in.path_id   = a_data_ff.path_id;
      b_data_in.eligible  = a_data_ff.is_active && a_data_ff.has_buffer &&
                            a_data_ff.may_send &&
                            (32'(a_data_ff.path_id) < 32'(MAX_PATHS));
      b_data_in.is_backup = a_data_ff.is_backup;
      b_data_in.backlog   = a_data_ff.write_seq_num - a_data_ff.next_seq_num;
      b_data_in.win_bytes = a_data_ff.cong_window * a_data_ff.seg_size;
      b_data_in.rtt       = a_data_ff.smoothed_rtt[lrps_pkg::SRTT_W-1:lrps_pkg::RTT_SHIFT];
      b_data_in.last_path = a_data_ff.last_path;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_data_ff <= req_data;
      end
      if (b_load) begin
         b_data_ff <= b_data_in;
      end
   end

   assign info_valid = b_valid_ff;
   assign info_data  = b_data_ff;

endmodule

// ----- hw/rtl/lrps_rtt_select.sv -----
// ---------------------------------------------------------------------------
// RTT selection stage
// Backlog check, lowest-RTT tracking over a round and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lowest_rtt_path_select_top_assert.svh"

module lrps_rtt_select (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [lrps_pkg::FACTOR_W-1:0]    backlog_factor,
   input  logic                             info_valid,
   output logic                             info_ready,
   input  lrps_pkg::path_info_type          info_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output lrps_pkg::rsp_type                rsp_data
);

   logic [lrps_pkg::RTT_W-1:0]   best_rtt_ff, best_rtt_in;
   logic [lrps_pkg::ID_W-1:0]    best_id_ff, best_id_in;
   logic                         best_backup_ff, best_backup_in;
   logic                         have_best_ff, have_best_in;
   logic                         out_valid_ff, out_valid_in;
   lrps_pkg::rsp_type            out_data_ff, out_data_in;

   logic [lrps_pkg::BOUND_W+lrps_pkg::FACTOR_W-1:0] bound_full;
   logic [lrps_pkg::BOUND_W-1:0] bound;
   logic                         qualifies;
   logic                         take;
   logic                         out_ready;
   logic                         consume;
   logic                         cand_have;
   logic [lrps_pkg::ID_W-1:0]    cand_id;
   logic [lrps_pkg::RTT_W-1:0]   cand_rtt;
   logic                         cand_backup;

   assign out_ready  = !out_valid_ff || rsp_ready;
   assign info_ready = !info_data.last_path || out_ready;
   assign consume    = info_valid && info_ready;

   // Bound wraps to 32 bits.
   assign bound_full = backlog_factor * info_data.win_bytes;
   assign bound      = bound_full[lrps_pkg::BOUND_W-1:0];
   assign qualifies  = info_data.eligible && (info_data.backlog <= bound);

   // Strictly lower RTT wins; on a tie a primary path displaces a backup one.
   assign take = qualifies &&
                 (!have_best_ff || (info_data.rtt < best_rtt_ff) ||
                  ((info_data.rtt == best_rtt_ff) && best_backup_ff &&
                   !info_data.is_backup));

   always_comb begin
      cand_have   = have_best_ff || take;
      cand_id     = take ? info_data.path_id : best_id_ff;
      cand_rtt    = take ? info_data.rtt : best_rtt_ff;
      cand_backup = take ? info_data.is_backup : best_backup_ff;
   end

   always_comb begin
      best_rtt_in    = best_rtt_ff;
      best_id_in     = best_id_ff;
      best_backup_in = best_backup_ff;
      have_best_in   = have_best_ff;
      if (consume) begin
         if (info_data.last_path) begin
            best_rtt_in    = lrps_pkg::RTT_ALL_ONES;
            best_id_in     = '0;
            best_backup_in = 1'b0;
            have_best_in   = 1'b0;
         end else begin
            best_rtt_in    = cand_rtt;
            best_id_in     = cand_id;
            best_backup_in = cand_backup;
            have_best_in   = cand_have;
         end
      end
   end

   always_comb begin
      out_valid_in           = out_ready ? (consume && info_data.last_path) : out_valid_ff;
      out_data_in.found      = cand_have;
      out_data_in.chosen_id  = cand_have ? cand_id : '0;
      out_data_in.chosen_rtt = cand_have ? cand_rtt : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_rtt_ff    <= lrps_pkg::RTT_ALL_ONES;
         best_id_ff     <= '0;
         best_backup_ff <= 1'b0;
         have_best_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         best_rtt_ff    <= best_rtt_in;
         best_id_ff     <= best_id_in;
         best_backup_ff <= best_backup_in;
         have_best_ff   <= have_best_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && info_data.last_path) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `LRPS_ASSERT_IMPL(a_empty_result, clock, reset, rsp_valid && !rsp_data.found, rsp_data.chosen_id == '0 && rsp_data.chosen_rtt == '0)
   `LRPS_ASSERT_NEXT(a_round_clear, clock, reset, consume && info_data.last_path, !have_best_ff && best_rtt_ff == lrps_pkg::RTT_ALL_ONES)
   `LRPS_ASSERT_IMPL(a_idle_state, clock, reset, !have_best_ff, best_rtt_ff == lrps_pkg::RTT_ALL_ONES && best_id_ff == '0 && !best_backup_ff)
   `LRPS_ASSERT_NEXT(a_result_source, clock, reset, !rsp_valid && !(consume && info_data.last_path), !rsp_valid)

endmodule

// ----- dv/tb_lowest_rtt_path_select_top.sv -----
// ---------------------------------------------------------------------------
// Lowest RTT path select testbench
// Streams rounds of candidate path descriptors into the selector, predicts
// the winner of every round in a local scoreboard and compares each
// response field by field. Backlog factor settings are changed between
// phases and read back over the register port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lowest_rtt_path_select_top;

   localparam int unsigned DRAIN_CYCLES   = 8;     // pipeline is three deep
   localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles without any transfer or register select
   localparam int unsigned HOLDOFF_CYCLES = 300;
   localparam int unsigned SEGMENT_PATHS  = 315;
   localparam int unsigned NUM_SEGMENTS   = 6;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [lrps_pkg::REQ_TDATA_W-1:0]    req_tdata = '0;
   logic                                req_tlast = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [lrps_pkg::RSP_TDATA_W-1:0]    rsp_tdata;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [lrps_pkg::CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [lrps_pkg::CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [lrps_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   lowest_rtt_path_select_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Scoreboard state: the local copy of the register, the best path of the
   // open round, and the choices still waiting to come out of the block.
   // ------------------------------------------------------------------------
   logic [lrps_pkg::FACTOR_W-1:0] factor_model = lrps_pkg::BACKLOG_RESET;
   logic [lrps_pkg::RTT_W-1:0]    round_best_rtt = lrps_pkg::RTT_ALL_ONES;
   logic [lrps_pkg::ID_W-1:0]     round_best_id = '0;
   logic                          round_best_backup = 1'b0;
   logic                          round_has_best = 1'b0;

   lrps_pkg::path_req_type path_queue[$];
   lrps_pkg::rsp_type      expected_choices[$];

   int unsigned mismatch_count = 0;
   int unsigned paths_sent = 0;
   int unsigned rounds_checked = 0;
   int unsigned rounds_found = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned holdoff_requests = 0;
   int unsigned holdoff_served = 0;
   int unsigned holdoff_left = 0;
   int unsigned quiet_cycles = 0;

   // Compare-and-update of one accepted path; close the round on last_path.
   function automatic void select_lowest_rtt(input lrps_pkg::path_req_type p);
      logic [lrps_pkg::SEQ_W-1:0]   backlog;
      logic [lrps_pkg::BOUND_W-1:0] bound;
      logic [lrps_pkg::RTT_W-1:0]   rtt;
      logic                         qualifies;
      logic                         take;
      lrps_pkg::rsp_type            choice;
      backlog   = p.write_seq_num - p.next_seq_num;
      // 32-bit context keeps the wrapped product
      bound     = factor_model * p.cong_window * p.seg_size;
      rtt       = p.smoothed_rtt[lrps_pkg::SRTT_W-1:lrps_pkg::RTT_SHIFT];
      qualifies = p.is_active && p.has_buffer && p.may_send &&
                  (p.path_id < lrps_pkg::MAX_PATHS) && (backlog <= bound);
      if (qualifies) begin
         if (!round_has_best)
            take = 1'b1;
         else if (rtt < round_best_rtt)
            take = 1'b1;
         else
            take = (rtt == round_best_rtt) && round_best_backup && !p.is_backup;
         if (take) begin
            round_best_rtt    = rtt;
            round_best_id     = p.path_id;
            round_best_backup = p.is_backup;
            round_has_best    = 1'b1;
         end
      end
      if (p.last_path) begin
         choice.found      = round_has_best;
         choice.chosen_id  = round_has_best ? round_best_id : '0;
         choice.chosen_rtt = round_has_best ? round_best_rtt : '0;
         expected_choices.push_back(choice);
         round_best_rtt    = lrps_pkg::RTT_ALL_ONES;
         round_best_id     = '0;
         round_best_backup = 1'b0;
         round_has_best    = 1'b0;
      end
   endfunction

   function automatic logic [lrps_pkg::REQ_TDATA_W-1:0] pack_path(
      input lrps_pkg::path_req_type p);
      return {1'b0, p.smoothed_rtt, p.seg_size, p.cong_window, p.next_seq_num,
              p.write_seq_num, p.is_backup, p.may_send, p.has_buffer,
              p.is_active, p.path_id};
   endfunction

   function automatic lrps_pkg::path_req_type make_path(
      input logic [lrps_pkg::ID_W-1:0] id, input logic act, input logic room,
      input logic may, input logic bk, input logic [lrps_pkg::SEQ_W-1:0] wseq,
      input logic [lrps_pkg::SEQ_W-1:0] nseq,
      input logic [lrps_pkg::WIN_W-1:0] cwnd,
      input logic [lrps_pkg::WIN_W-1:0] mss,
      input logic [lrps_pkg::SRTT_W-1:0] srtt,
      input logic last);
      lrps_pkg::path_req_type p;
      p.path_id       = id;
      p.is_active     = act;
      p.has_buffer    = room;
      p.may_send      = may;
      p.is_backup     = bk;
      p.write_seq_num = wseq;
      p.next_seq_num  = nseq;
      p.cong_window   = cwnd;
      p.seg_size      = mss;
      p.smoothed_rtt  = srtt;
      p.last_path     = last;
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: hold the current transfer until it is taken, then
   // advance to the next queued path or idle at the configured rate. The
   // prediction runs on the accepted path before a new one is loaded.
   // ------------------------------------------------------------------------
   lrps_pkg::path_req_type drive_path;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            select_lowest_rtt(drive_path);
            paths_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (path_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_path = path_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= pack_path(drive_path);
               req_tlast  <= drive_path.last_path;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response side: random stalls, plus a long hold-off on request so the
   // block backs up behind an untaken result and stalls its input.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else if (holdoff_requests != holdoff_served) begin
         holdoff_served = holdoff_requests;
         holdoff_left   = HOLDOFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check every result transfer against the oldest waiting choice.
   always @(posedge clock) begin
      lrps_pkg::rsp_type seen;
      lrps_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.found      = rsp_tdata[0];
         seen.chosen_id  = rsp_tdata[1 +: lrps_pkg::ID_W];
         seen.chosen_rtt = rsp_tdata[1 + lrps_pkg::ID_W +: lrps_pkg::RTT_W];
         if (expected_choices.size() == 0) begin
            if (mismatch_count < 10)
               $display("[%0t] unexpected result: found=%0d id=%0d rtt=%0d",
                        $time, seen.found, seen.chosen_id, seen.chosen_rtt);
            mismatch_count++;
         end else begin
            want = expected_choices.pop_front();
            rounds_checked++;
            if (want.found)
               rounds_found++;
            if (seen.found != want.found || seen.chosen_id != want.chosen_id ||
                seen.chosen_rtt != want.chosen_rtt) begin
               if (mismatch_count < 10)
                  $display("[%0t] result mismatch: expected found=%0d id=%0d rtt=%0d, %s%0d %0d %0d",
                           $time, want.found, want.chosen_id, want.chosen_rtt,
                           "got ", seen.found, seen.chosen_id, seen.chosen_rtt);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves on any port for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding",
                  expected_choices.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Wait until every queued path is taken and every result has come back,
   // then give the pipeline time to flush paths that close no round.
   task automatic wait_idle();
      do @(negedge clock);
      while (path_queue.size() != 0 || req_tvalid || expected_choices.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the backlog factor (upper data bits are junk) and read it back.
   task automatic set_backlog_factor(input logic [lrps_pkg::FACTOR_W-1:0] value);
      logic [lrps_pkg::CSR_DATA_W-1:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= lrps_pkg::CSR_BACKLOG_FACTOR;
      csr_pwdata  <= ($urandom() & ~32'hF) | value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      factor_model = value;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      readback = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback != lrps_pkg::CSR_DATA_W'(value)) begin
         if (mismatch_count < 10)
            $display("[%0t] backlog_factor readback: expected %0d, got %0d",
                     $time, value, readback);
         mismatch_count++;
      end
   endtask

   // One random round. Mostly well-formed eligible paths with backlogs near
   // the bound and RTTs from a narrow pool so ties and backup displacement
   // happen often; the rest is noise with random flags and full-range fields.
   task automatic push_random_round(inout int unsigned pushed);
      int unsigned                  n;
      int unsigned                  r;
      logic [lrps_pkg::SRTT_W-1:0]  tie_base;
      lrps_pkg::path_req_type       p;
      logic [lrps_pkg::BOUND_W-1:0] bound;
      logic [lrps_pkg::SEQ_W-1:0]   backlog;
      r = $urandom_range(99);
      n = (r < 85) ? $urandom_range(8, 1) : (r < 95) ? $urandom_range(12, 9) : 1;
      tie_base = $urandom_range(40);
      for (int i = 0; i < n; i++) begin
         p.path_id    = (n <= 8) ? lrps_pkg::ID_W'((i + tie_base) % 8) :
                                   lrps_pkg::ID_W'($urandom_range(7));
         p.is_backup  = ($urandom_range(99) < 30);
         r = $urandom_range(99);
         if (r < 85) begin
            p.is_active  = 1'b1;
            p.has_buffer = 1'b1;
            p.may_send   = 1'b1;
         end else begin
            p.is_active  = $urandom_range(1);
            p.has_buffer = $urandom_range(1);
            p.may_send   = $urandom_range(1);
         end
         if ($urandom_range(99) < 70) begin
            p.cong_window = $urandom_range(100, 1);
            p.seg_size    = $urandom_range(1500, 500);
         end else begin
            p.cong_window = $urandom();
            p.seg_size    = $urandom();
         end
         bound = factor_model * p.cong_window * p.seg_size;
         r = $urandom_range(99);
         if (r < 60)
            backlog = lrps_pkg::SEQ_W'({$urandom(), $urandom()} %
                                       (64'(bound) + 64'd1));
         else if (r < 75)
            backlog = bound;
         else if (r < 85)
            backlog = bound + 1;
         else
            backlog = $urandom();
         p.next_seq_num  = $urandom();
         p.write_seq_num = p.next_seq_num + backlog;
         r = $urandom_range(99);
         if (r < 50)
            p.smoothed_rtt = ((tie_base + $urandom_range(3)) << lrps_pkg::RTT_SHIFT) |
                             $urandom_range(7);
         else if (r < 92)
            p.smoothed_rtt = $urandom();
         else
            p.smoothed_rtt = '1 - $urandom_range(7);
         p.last_path = (i == n - 1);
         path_queue.push_back(p);
         pushed++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [lrps_pkg::FACTOR_W-1:0] segment_factor[NUM_SEGMENTS];
      int unsigned                   pushed;
      segment_factor = '{4'd15, 4'd0, 4'd1, 4'($urandom_range(14, 3)), 4'd0, 4'd15};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 31;
      recv_idle_pct = 75;

      // Directed rounds under the reset factor of 2. With cwnd 10 and mss
      // 1000 the bound is 20000; with both at their maximum it wraps.
      // Lone path with all-ones RTT is still taken.
      path_queue.push_back(make_path(7, 1, 1, 1, 1, 100, 100, 10, 1000, '1, 1));
      // Each eligibility flag dropped in turn, then backlog one over bound.
      path_queue.push_back(make_path(1, 0, 1, 1, 0, 0, 0, 10, 1000, 8, 0));
      path_queue.push_back(make_path(2, 1, 0, 1, 0, 0, 0, 10, 1000, 8, 0));
      path_queue.push_back(make_path(3, 1, 1, 0, 0, 0, 0, 10, 1000, 8, 0));
      path_queue.push_back(make_path(4, 1, 1, 1, 0, 20001, 0, 10, 1000, 8, 1));
      // Equal RTT: primary displaces backup, later backup and primary do not.
      path_queue.push_back(make_path(0, 1, 1, 1, 1, 5, 0, 10, 1000, 800, 0));
      path_queue.push_back(make_path(1, 1, 1, 1, 0, 5, 0, 10, 1000, 807, 0));
      path_queue.push_back(make_path(2, 1, 1, 1, 1, 5, 0, 10, 1000, 800, 0));
      path_queue.push_back(make_path(3, 1, 1, 1, 0, 5, 0, 10, 1000, 801, 1));
      // Backlog exactly at bound qualifies, one above does not.
      path_queue.push_back(make_path(5, 1, 1, 1, 0, 20000 + 77, 77, 10, 1000, 0, 0));
      path_queue.push_back(make_path(6, 1, 1, 1, 0, 20001 + 77, 77, 10, 1000, 0, 1));
      // Wrapped product bound, one over it, and a zero window with a
      // sequence wrap giving the largest backlog.
      path_queue.push_back(make_path(2, 1, 1, 1, 0, 32'hFFFC_0002, 0, '1, '1, 1000, 0));
      path_queue.push_back(make_path(3, 1, 1, 1, 0, 32'hFFFC_0003, 0, '1, '1, 8, 0));
      path_queue.push_back(make_path(4, 1, 1, 1, 0, 0, 1, 0, 1000, 0, 1));
      // Lower RTT later in the round replaces; all-max fields path fails.
      path_queue.push_back(make_path(0, 1, 1, 1, 0, 1, 0, 10, 1000, 64, 0));
      path_queue.push_back(make_path(1, 1, 1, 1, 0, 1, 0, 10, 1000, 16, 0));
      path_queue.push_back(make_path(7, 1, 1, 1, 1, '1, 0, '1, '1, '1, 1));
      // Everything zero: nothing qualifies.
      path_queue.push_back(make_path(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      wait_idle();

      for (int s = 0; s < NUM_SEGMENTS; s++) begin
         // idle pattern: sender light / receiver heavy, then swapped, then none
         send_idle_pct = (s < 2) ? 31 : (s < 4) ? 75 : 0;
         recv_idle_pct = (s < 2) ? 75 : (s < 4) ? 31 : 0;
         set_backlog_factor(segment_factor[s]);
         if (s == 4)
            holdoff_requests++;
         pushed = 0;
         while (pushed < SEGMENT_PATHS)
            push_random_round(pushed);
         // the drain between segments doubles as the sender pause
         wait_idle();
      end

      $display("Sent %0d paths; checked %0d rounds, %0d with a chosen path.",
               paths_sent, rounds_checked, rounds_found);
      $display("Backlog factors covered reset, 0, 1, mid and 15; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && expected_choices.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
